@@ rtl/core/grid_ray_dda_caster_core_assert.svh @@
// Assertion macros used by the caster controller.
`ifndef GRID_RAY_DDA_CASTER_CORE_ASSERT_SVH
`define GRID_RAY_DDA_CASTER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset
`define GDC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define GDC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/gdc_pkg.sv @@
`default_nettype none

package gdc_pkg;

    // Fixed point format and field widths
    localparam int FRAC_BITS     = 16;
    localparam int MAP_SIDE_DEF  = 32;
    localparam int MAX_STEPS_DEF = 64;

    localparam int POS_W      = 21;
    localparam int VEC_W      = 19;
    localparam int COLS_W     = 13;
    localparam int COL_W      = 12;
    localparam int CELL_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int CAM_W      = FRAC_BITS + 2;
    localparam int RAY_W      = FRAC_BITS + 4;
    localparam int MAG_W      = FRAC_BITS + 3;
    localparam int PART_W     = FRAC_BITS + 1;
    localparam int DIST_W     = 32;
    localparam int DIV_NUM_W  = 2 * FRAC_BITS + 1;
    localparam int DIV_DEN_W  = RAY_W;
    localparam int MUL_A_W    = VEC_W;
    localparam int MUL_B_W    = DIST_W + 2;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    // Opcodes of an input word
    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_CAST  = 1'b1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POS_X   = 3'd0,
        REG_POS_Y   = 3'd1,
        REG_DIR_X   = 3'd2,
        REG_DIR_Y   = 3'd3,
        REG_PLANE_X = 3'd4,
        REG_PLANE_Y = 3'd5,
        REG_COLS    = 3'd6
    } t_cfg_reg;

    typedef enum logic [1:0] {
        DIV_CAM,
        DIV_DX,
        DIV_DY
    } t_div_sel;

    typedef enum logic [1:0] {
        MUL_RX,
        MUL_RY,
        MUL_SX,
        MUL_SY
    } t_mul_sel;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CAM_W,
        S_MRX,
        S_MRY,
        S_RY,
        S_DX_W,
        S_DY_W,
        S_MSX,
        S_MSY,
        S_SY,
        S_RD,
        S_CHK,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic     clr_we;
        logic     map_we;
        logic     cast_load;
        logic     div_start;
        t_div_sel div_sel;
        t_mul_sel mul_sel;
        logic     cam_take;
        logic     rx_take;
        logic     ry_take;
        logic     dx_take;
        logic     dy_take;
        logic     sx_take;
        logic     sy_take;
        logic     rd;
        logic     step;
        logic     set_ovf;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic in_map;
        logic wall;
        logic steps_max;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/core/gdc_ram.sv @@
`default_nettype none

module gdc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/core/gdc_div.sv @@
`default_nettype none

module gdc_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [gdc_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic [gdc_pkg::DIV_DEN_W-1:0] i_den,
    output logic                                o_done,
    output logic      [gdc_pkg::DIV_NUM_W-1:0] o_quot
);

    localparam int NW = gdc_pkg::DIV_NUM_W;
    localparam int DW = gdc_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_quo;
    logic [DW:0]      r_rem;
    logic [DW-1:0]    r_den;
    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_nx;
    logic             ge;

    // Restoring division, one quotient bit per cycle; a zero divisor gives all ones
    always_comb begin
        rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_nx = ge ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= rem_nx;
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

`default_nettype wire

@@ rtl/core/gdc_dp.sv @@
`default_nettype none

module gdc_dp #(
    parameter int MAP_SIDE  = gdc_pkg::MAP_SIDE_DEF,
    parameter int MAX_STEPS = gdc_pkg::MAX_STEPS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [gdc_pkg::CELL_W-1:0]     i_cell_x,
    input  wire logic [gdc_pkg::CELL_W-1:0]     i_cell_y,
    input  wire logic                            i_cell_wall,
    input  wire logic [gdc_pkg::COL_W-1:0]      i_column,
    input  wire gdc_pkg::t_cmd                   i_cmd,
    output gdc_pkg::t_status                     o_status,
    input  wire logic                            i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_wall_side,
    output logic      [gdc_pkg::CELL_W-1:0]     o_hit_cell_x,
    output logic      [gdc_pkg::CELL_W-1:0]     o_hit_cell_y,
    output logic      [gdc_pkg::DIST_W-1:0]     o_side_dist_x,
    output logic      [gdc_pkg::DIST_W-1:0]     o_side_dist_y,
    output logic                                 o_walk_overflow
);

    localparam int F      = gdc_pkg::FRAC_BITS;
    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(MAP_SIDE);
    localparam int XW     = ((CW > gdc_pkg::CELL_W) ? CW : gdc_pkg::CELL_W) + 2;
    localparam int SW     = $clog2(MAX_STEPS + 1);
    localparam int POS_W  = gdc_pkg::POS_W;
    localparam int VEC_W  = gdc_pkg::VEC_W;
    localparam int COLS_W = gdc_pkg::COLS_W;
    localparam int CAM_W  = gdc_pkg::CAM_W;
    localparam int RAY_W  = gdc_pkg::RAY_W;
    localparam int MAG_W  = gdc_pkg::MAG_W;
    localparam int PART_W = gdc_pkg::PART_W;
    localparam int DIST_W = gdc_pkg::DIST_W;
    localparam int NW     = gdc_pkg::DIV_NUM_W;
    localparam int DW     = gdc_pkg::DIV_DEN_W;
    localparam int MA_W   = gdc_pkg::MUL_A_W;
    localparam int MB_W   = gdc_pkg::MUL_B_W;
    localparam int PR_W   = gdc_pkg::PROD_W;

    // Configuration registers
    logic        [POS_W-1:0]  r_pos_x, r_pos_y;
    logic signed [VEC_W-1:0]  r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic        [COLS_W-1:0] r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= POS_W'(1081344);
            r_pos_y   <= POS_W'(1081344);
            r_dir_x   <= -VEC_W'(65536);
            r_dir_y   <= '0;
            r_plane_x <= '0;
            r_plane_y <= VEC_W'(43254);
            r_cols    <= COLS_W'(640);
        end else if (i_cfg_we) begin
            case (gdc_pkg::t_cfg_reg'(i_cfg_idx))
                gdc_pkg::REG_POS_X:   r_pos_x   <= i_cfg_data[POS_W-1:0];
                gdc_pkg::REG_POS_Y:   r_pos_y   <= i_cfg_data[POS_W-1:0];
                gdc_pkg::REG_DIR_X:   r_dir_x   <= i_cfg_data[VEC_W-1:0];
                gdc_pkg::REG_DIR_Y:   r_dir_y   <= i_cfg_data[VEC_W-1:0];
                gdc_pkg::REG_PLANE_X: r_plane_x <= i_cfg_data[VEC_W-1:0];
                gdc_pkg::REG_PLANE_Y: r_plane_y <= i_cfg_data[VEC_W-1:0];
                gdc_pkg::REG_COLS:    r_cols    <= i_cfg_data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Working registers
    logic signed [CAM_W-1:0] r_cam;
    logic signed [RAY_W-1:0] r_ray_x, r_ray_y;
    logic [DIST_W-1:0]       r_dx, r_dy, r_sx, r_sy;
    logic signed [PR_W-1:0]  r_prod;
    logic signed [XW-1:0]    r_mx, r_my;
    logic [SW-1:0]           r_n;
    logic                    r_side;
    logic                    r_ovf;
    logic [AW-1:0]           r_clr_cnt;

    // Camera offset operands: clamp column, zero width acts as one
    logic [COLS_W-1:0] width;
    logic [COLS_W-1:0] col_c;
    always_comb begin
        width = (r_cols == '0) ? COLS_W'(1) : r_cols;
        col_c = (COLS_W'(i_column) >= width) ? (width - COLS_W'(1)) : COLS_W'(i_column);
    end

    // Ray magnitudes and direction signs
    logic neg_x, neg_y;
    logic [MAG_W-1:0] mag_x, mag_y;
    always_comb begin
        neg_x = r_ray_x[RAY_W-1];
        neg_y = r_ray_y[RAY_W-1];
        mag_x = neg_x ? MAG_W'(-r_ray_x) : MAG_W'(r_ray_x);
        mag_y = neg_y ? MAG_W'(-r_ray_y) : MAG_W'(r_ray_y);
    end

    // Shared divider
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic [NW-1:0] div_quot;
    logic          div_done;
    always_comb begin
        case (i_cmd.div_sel)
            gdc_pkg::DIV_DX: begin
                div_num = NW'(1) << (2 * F);
                div_den = DW'(mag_x);
            end
            gdc_pkg::DIV_DY: begin
                div_num = NW'(1) << (2 * F);
                div_den = DW'(mag_y);
            end
            default: begin
                div_num = NW'(col_c) << (F + 1);
                div_den = DW'(width);
            end
        endcase
    end

    gdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Shared multiplier, product registered every cycle
    logic [PART_W-1:0] part_x, part_y;
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    always_comb begin
        part_x = neg_x ? {1'b0, r_pos_x[F-1:0]}
                       : (PART_W'(1) << F) - {1'b0, r_pos_x[F-1:0]};
        part_y = neg_y ? {1'b0, r_pos_y[F-1:0]}
                       : (PART_W'(1) << F) - {1'b0, r_pos_y[F-1:0]};
        case (i_cmd.mul_sel)
            gdc_pkg::MUL_RY: begin
                mul_a = r_plane_y;
                mul_b = MB_W'(r_cam);
            end
            gdc_pkg::MUL_SX: begin
                mul_a = signed'(MA_W'(part_x));
                mul_b = signed'(MB_W'(r_dx));
            end
            gdc_pkg::MUL_SY: begin
                mul_a = signed'(MA_W'(part_y));
                mul_b = signed'(MB_W'(r_dy));
            end
            default: begin
                mul_a = r_plane_x;
                mul_b = MB_W'(r_cam);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Scaled product and its saturated distance form
    logic signed [PR_W-1:0] prod_sh;
    logic [DIST_W-1:0]      prod_sat;
    always_comb begin
        prod_sh  = r_prod >>> F;
        prod_sat = (|prod_sh[PR_W-1:DIST_W]) ? '1 : prod_sh[DIST_W-1:0];
    end

    // Walk step arithmetic
    logic [DIST_W:0] sum_x, sum_y;
    logic            go_x;
    always_comb begin
        sum_x = {1'b0, r_sx} + {1'b0, r_dx};
        sum_y = {1'b0, r_sy} + {1'b0, r_dy};
        go_x  = r_sx < r_sy;
    end

    // Setup and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cast_load) begin
            r_mx   <= XW'(r_pos_x[POS_W-1:F]);
            r_my   <= XW'(r_pos_y[POS_W-1:F]);
            r_n    <= '0;
            r_side <= 1'b0;
            r_ovf  <= 1'b0;
        end
        if (i_cmd.cam_take) begin
            r_cam <= CAM_W'(div_quot) - CAM_W'(1 << F);
        end
        if (i_cmd.rx_take) begin
            r_ray_x <= RAY_W'(prod_sh) + RAY_W'(r_dir_x);
        end
        if (i_cmd.ry_take) begin
            r_ray_y <= RAY_W'(prod_sh) + RAY_W'(r_dir_y);
        end
        if (i_cmd.dx_take) begin
            r_dx <= div_quot[NW-1] ? '1 : div_quot[DIST_W-1:0];
        end
        if (i_cmd.dy_take) begin
            r_dy <= div_quot[NW-1] ? '1 : div_quot[DIST_W-1:0];
        end
        if (i_cmd.sx_take) begin
            r_sx <= prod_sat;
        end
        if (i_cmd.sy_take) begin
            r_sy <= prod_sat;
        end
        if (i_cmd.set_ovf) begin
            r_ovf <= 1'b1;
        end
        if (i_cmd.step) begin
            r_n <= r_n + SW'(1);
            if (go_x) begin
                r_sx   <= sum_x[DIST_W] ? '1 : sum_x[DIST_W-1:0];
                r_mx   <= neg_x ? (r_mx - XW'(1)) : (r_mx + XW'(1));
                r_side <= 1'b0;
            end else begin
                r_sy   <= sum_y[DIST_W] ? '1 : sum_y[DIST_W-1:0];
                r_my   <= neg_y ? (r_my - XW'(1)) : (r_my + XW'(1));
                r_side <= 1'b1;
            end
        end
    end

    // Clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // Wall map
    logic          wr_ok;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;
    always_comb begin
        wr_ok     = (32'(i_cell_x) < MAP_SIDE) && (32'(i_cell_y) < MAP_SIDE);
        ram_we    = i_cmd.clr_we || (i_cmd.map_we && wr_ok);
        ram_waddr = i_cmd.clr_we ? r_clr_cnt
                  : (AW'(i_cell_y) * AW'(MAP_SIDE) + AW'(i_cell_x));
        ram_wdata = i_cmd.clr_we ? 1'b0 : i_cell_wall;
        ram_raddr = AW'($unsigned(r_my)) * AW'(MAP_SIDE) + AW'($unsigned(r_mx));
    end

    gdc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Output register
    logic r_out_valid;
    logic r_o_side, r_o_ovf;
    logic [gdc_pkg::CELL_W-1:0] r_o_cx, r_o_cy;
    logic [DIST_W-1:0] r_o_sx, r_o_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_side <= r_side;
            r_o_ovf  <= r_ovf;
            r_o_cx   <= r_mx[gdc_pkg::CELL_W-1:0];
            r_o_cy   <= r_my[gdc_pkg::CELL_W-1:0];
            r_o_sx   <= r_sx;
            r_o_sy   <= r_sy;
        end
    end

    // Status to the controller
    always_comb begin
        o_status.clr_last  = r_clr_cnt == AW'(DEPTH - 1);
        o_status.div_done  = div_done;
        o_status.in_map    = !r_mx[XW-1] && !r_my[XW-1]
                          && (r_mx < XW'(MAP_SIDE)) && (r_my < XW'(MAP_SIDE));
        o_status.wall      = ram_rdata;
        o_status.steps_max = r_n == SW'(MAX_STEPS);
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_wall_side     = r_o_side;
    assign o_hit_cell_x    = r_o_cx;
    assign o_hit_cell_y    = r_o_cy;
    assign o_side_dist_x   = r_o_sx;
    assign o_side_dist_y   = r_o_sy;
    assign o_walk_overflow = r_o_ovf;

endmodule

`default_nettype wire

@@ rtl/core/gdc_ctrl.sv @@
`default_nettype none

`include "grid_ray_dda_caster_core_assert.svh"

module gdc_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_opcode,
    output logic                  o_in_stall,
    input  wire gdc_pkg::t_status i_status,
    output gdc_pkg::t_cmd         o_cmd
);

    gdc_pkg::t_state r_state, n_state;
    logic accept;

    assign accept = i_in_valid && (r_state == gdc_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gdc_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gdc_pkg::S_CLEAR: if (i_status.clr_last) n_state = gdc_pkg::S_IDLE;
            gdc_pkg::S_IDLE: begin
                if (accept && (i_opcode == gdc_pkg::OPC_CAST)) begin
                    n_state = gdc_pkg::S_CAM_W;
                end
            end
            gdc_pkg::S_CAM_W: if (i_status.div_done) n_state = gdc_pkg::S_MRX;
            gdc_pkg::S_MRX:   n_state = gdc_pkg::S_MRY;
            gdc_pkg::S_MRY:   n_state = gdc_pkg::S_RY;
            gdc_pkg::S_RY:    n_state = gdc_pkg::S_DX_W;
            gdc_pkg::S_DX_W:  if (i_status.div_done) n_state = gdc_pkg::S_DY_W;
            gdc_pkg::S_DY_W:  if (i_status.div_done) n_state = gdc_pkg::S_MSX;
            gdc_pkg::S_MSX:   n_state = gdc_pkg::S_MSY;
            gdc_pkg::S_MSY:   n_state = gdc_pkg::S_SY;
            gdc_pkg::S_SY:    n_state = gdc_pkg::S_RD;
            gdc_pkg::S_RD:    n_state = i_status.in_map ? gdc_pkg::S_CHK : gdc_pkg::S_DONE;
            gdc_pkg::S_CHK: begin
                if (i_status.wall || i_status.steps_max) begin
                    n_state = gdc_pkg::S_DONE;
                end else begin
                    n_state = gdc_pkg::S_RD;
                end
            end
            gdc_pkg::S_DONE:  if (i_status.out_free) n_state = gdc_pkg::S_IDLE;
            default:          n_state = gdc_pkg::S_CLEAR;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = gdc_pkg::DIV_CAM;
        o_cmd.mul_sel = gdc_pkg::MUL_RX;
        o_in_stall    = r_state != gdc_pkg::S_IDLE;
        case (r_state)
            gdc_pkg::S_CLEAR: o_cmd.clr_we = 1'b1;
            gdc_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_opcode == gdc_pkg::OPC_CAST) begin
                        o_cmd.cast_load = 1'b1;
                        o_cmd.div_start = 1'b1;
                    end else begin
                        o_cmd.map_we = 1'b1;
                    end
                end
            end
            gdc_pkg::S_CAM_W: o_cmd.cam_take = i_status.div_done;
            gdc_pkg::S_MRX:   o_cmd.mul_sel = gdc_pkg::MUL_RX;
            gdc_pkg::S_MRY: begin
                o_cmd.rx_take = 1'b1;
                o_cmd.mul_sel = gdc_pkg::MUL_RY;
            end
            gdc_pkg::S_RY: begin
                o_cmd.ry_take   = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = gdc_pkg::DIV_DX;
            end
            gdc_pkg::S_DX_W: begin
                o_cmd.dx_take   = i_status.div_done;
                o_cmd.div_start = i_status.div_done;
                o_cmd.div_sel   = gdc_pkg::DIV_DY;
            end
            gdc_pkg::S_DY_W:  o_cmd.dy_take = i_status.div_done;
            gdc_pkg::S_MSX:   o_cmd.mul_sel = gdc_pkg::MUL_SX;
            gdc_pkg::S_MSY: begin
                o_cmd.sx_take = 1'b1;
                o_cmd.mul_sel = gdc_pkg::MUL_SY;
            end
            gdc_pkg::S_SY:    o_cmd.sy_take = 1'b1;
            gdc_pkg::S_RD: begin
                o_cmd.rd      = i_status.in_map;
                o_cmd.set_ovf = !i_status.in_map;
            end
            gdc_pkg::S_CHK: begin
                if (!i_status.wall) begin
                    o_cmd.set_ovf = i_status.steps_max;
                    o_cmd.step    = !i_status.steps_max;
                end
            end
            gdc_pkg::S_DONE:  o_cmd.out_load = i_status.out_free;
            default: ;
        endcase
    end

    // Checks
    `GDC_ASSERT_IMP(a_div_done_waiting, i_clk, i_rst_n, i_status.div_done,
        (r_state == gdc_pkg::S_CAM_W) || (r_state == gdc_pkg::S_DX_W) || (r_state == gdc_pkg::S_DY_W),
        "divider finished outside a wait state")
    `GDC_ASSERT_IMP(a_out_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, i_status.out_free,
        "result register overwritten while held")
    `GDC_ASSERT_NXT(a_clear_complete, i_clk, i_rst_n,
        (r_state == gdc_pkg::S_CLEAR) && !i_status.clr_last, r_state == gdc_pkg::S_CLEAR,
        "map clearing left early")
    `GDC_ASSERT_IMP(a_step_legal, i_clk, i_rst_n, o_cmd.step,
        i_status.in_map && !i_status.wall && !i_status.steps_max,
        "walk stepped past a stop condition")

endmodule

`default_nettype wire

@@ rtl/core/grid_ray_dda_caster_core.sv @@
// DDA grid ray caster.
// Input channel (i_in_valid / o_in_stall): a word is either a map write
// (opcode 0: cell_x, cell_y, cell_wall) or a cast (opcode 1: column).
// Writes produce no result; each cast produces one result word on the output
// channel (o_out_valid / i_out_stall): wall side, hit cell, final side
// distances and an overflow flag.
// Configuration registers are written through i_cfg_we/i_cfg_idx/i_cfg_data;
// the user must do so only while the block is idle; it does not enforce this.
// A cast runs the shared bit-serial divider for the camera offset, shared
// multiplier steps for the ray, two more divider passes for the delta
// distances, multiplier steps for the side distances, then a registered
// map read and check for each walked cell.
// One cast is in flight at a time; the next word is taken while a finished
// result still waits in the output register.
// After reset all MAP_SIDE * MAP_SIDE map cells (1024 by default) are cleared
// while o_in_stall is high; registers take their reset values.
// If the receiver stalls, the result is held and a finished cast waits for
// the output register to free up before the block goes idle.
`default_nettype none

module grid_ray_dda_caster_core #(
    parameter int MAP_SIDE  = gdc_pkg::MAP_SIDE_DEF,
    parameter int MAX_STEPS = gdc_pkg::MAX_STEPS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gdc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gdc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_opcode,
    input  wire logic [gdc_pkg::CELL_W-1:0]     i_cell_x,
    input  wire logic [gdc_pkg::CELL_W-1:0]     i_cell_y,
    input  wire logic                            i_cell_wall,
    input  wire logic [gdc_pkg::COL_W-1:0]      i_column,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic                                 o_wall_side,
    output logic      [gdc_pkg::CELL_W-1:0]     o_hit_cell_x,
    output logic      [gdc_pkg::CELL_W-1:0]     o_hit_cell_y,
    output logic      [gdc_pkg::DIST_W-1:0]     o_side_dist_x,
    output logic      [gdc_pkg::DIST_W-1:0]     o_side_dist_y,
    output logic                                 o_walk_overflow
);

    gdc_pkg::t_cmd    cmd;
    gdc_pkg::t_status status;

    gdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gdc_dp #(
        .MAP_SIDE  (MAP_SIDE),
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_cell_x        (i_cell_x),
        .i_cell_y        (i_cell_y),
        .i_cell_wall     (i_cell_wall),
        .i_column        (i_column),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_wall_side     (o_wall_side),
        .o_hit_cell_x    (o_hit_cell_x),
        .o_hit_cell_y    (o_hit_cell_y),
        .o_side_dist_x   (o_side_dist_x),
        .o_side_dist_y   (o_side_dist_y),
        .o_walk_overflow (o_walk_overflow)
    );

endmodule

`default_nettype wire
